// ===== sv/sorted_key_table_unit_defines.svh =====
// Assertion macros used by the sorted key table sequencer.
// Depends on nothing; modules that assert must have clk and rst_n in scope.
`ifndef SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SKT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorted key table check failed");
`define SKT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");
`else
`define SKT_ASSERT_ALWAYS(label, cond)
`define SKT_ASSERT_IMPL(label, ante, cons)
`define SKT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/skt_pkg.sv =====
// Types and constants of the sorted key table.
// Depends on nothing; used by every module of the block.
package skt_pkg;

    localparam int TableDepth = 32;
    localparam int AddrW      = 5;
    localparam int CountW     = 6;
    localparam int KeyW       = 32;

    // Operation kinds.
    localparam logic [1:0] KindInsert = 2'd0;
    localparam logic [1:0] KindDelKey = 2'd1;
    localparam logic [1:0] KindDelIdx = 2'd2;
    localparam logic [1:0] KindLookup = 2'd3;

    // Result status codes.
    localparam logic [2:0] StInserted = 3'd0;
    localparam logic [2:0] StPresent  = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StDeleted  = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;
    localparam logic [2:0] StBadIndex = 3'd5;
    localparam logic [2:0] StFound    = 3'd6;

    // Configuration register indexes.
    localparam logic CfgCapacity = 1'b0;
    localparam logic CfgAllowDup = 1'b1;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KeyW-1:0]  key;
        logic [AddrW-1:0]        index;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CountW-1:0] position;
        logic [CountW-1:0] entry_count;
    } rsp_t;

    // Outcome of one key comparison.
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_t;

    // Settings seen by the sequencer; cap is already limited to the depth.
    typedef struct packed {
        logic [CountW-1:0] cap;
        logic              dup;
    } cfg_t;

    // Finished result offered by the sequencer.
    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } seq_res_t;

endpackage

// ===== sv/skt_cmp.sv =====
// Shared signed key comparator of the sorted key table.
// Depends on skt_pkg.
module skt_cmp (
    input  logic signed [skt_pkg::KeyW-1:0] key_a,
    input  logic signed [skt_pkg::KeyW-1:0] key_b,
    output skt_pkg::cmp_t                   result
);
    import skt_pkg::*;

    // Three-way signed compare of the search key against a stored key.
    always_comb
    begin
        result.lt = key_a < key_b;
        result.eq = key_a == key_b;
        result.gt = key_a > key_b;
    end

endmodule

// ===== sv/skt_mem.sv =====
// Key store of the sorted key table: one write port, one registered read port.
// Depends on skt_pkg.
module skt_mem (
    input  logic                     clk,
    input  logic                     we,
    input  logic [skt_pkg::AddrW-1:0] waddr,
    input  logic [skt_pkg::KeyW-1:0]  wdata,
    input  logic [skt_pkg::AddrW-1:0] raddr,
    output logic [skt_pkg::KeyW-1:0]  rdata_reg
);
    import skt_pkg::*;

    logic [KeyW-1:0] mem [TableDepth];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== sv/skt_seq.sv =====
// Sequencer of the sorted key table: binary search, shift sweeps, key count.
// Depends on skt_pkg, skt_cmp, skt_mem and the assertion macro header.
`include "sorted_key_table_unit_defines.svh"
module skt_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  skt_pkg::req_t     req,
    input  skt_pkg::cfg_t     cfg,
    output skt_pkg::seq_res_t res,
    input  logic              res_take
);
    import skt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HI     = 4'd1;
    localparam logic [3:0] S_LO     = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_MID    = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_UP     = 4'd6;
    localparam logic [3:0] S_PUT    = 4'd7;
    localparam logic [3:0] S_DN     = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [1:0]              kind_reg, kind_next;
    logic signed [KeyW-1:0]  key_reg, key_next;
    logic [AddrW-1:0]        lo_reg, lo_next;
    logic [AddrW-1:0]        hi_reg, hi_next;
    logic                    eqhi_reg, eqhi_next;
    logic                    found_reg, found_next;
    logic [CountW-1:0]       where_reg, where_next;
    logic [CountW-1:0]       count_reg, count_next;
    logic [CountW-1:0]       cur_reg, cur_next;
    logic [AddrW-1:0]        dst_reg, dst_next;
    logic                    pend_reg, pend_next;
    logic [2:0]              status_reg, status_next;
    logic [CountW-1:0]       pos_reg, pos_next;

    logic                    mem_we;
    logic [AddrW-1:0]        mem_waddr;
    logic [KeyW-1:0]         mem_wdata;
    logic [AddrW-1:0]        mem_raddr;
    logic [KeyW-1:0]         mem_rdata;
    cmp_t                    cmp;

    logic [CountW-1:0]       mid_sum;
    logic [AddrW-1:0]        mid;
    logic [CountW-1:0]       cnt_m1;
    logic [CountW-1:0]       cur_m1;
    logic [CountW-1:0]       hi_p1;

    skt_mem u_mem (
        .clk       (clk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

    skt_cmp u_cmp (
        .key_a  (key_reg),
        .key_b  ($signed(mem_rdata)),
        .result (cmp)
    );

    // Small arithmetic helpers around the search window.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CountW-1:1];
    assign cnt_m1  = count_reg - CountW'(1);
    assign cur_m1  = cur_reg - CountW'(1);
    assign hi_p1   = {1'b0, hi_reg} + CountW'(1);

    assign req_ready       = (state_reg == S_IDLE);
    assign res.valid       = (state_reg == S_FIN);
    assign res.rsp.status      = status_reg;
    assign res.rsp.position    = pos_reg;
    assign res.rsp.entry_count = count_reg;

    // Next-state and datapath control.
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        eqhi_next   = eqhi_reg;
        found_next  = found_reg;
        where_next  = where_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = dst_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = hi_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    key_next  = req.key;
                    if (req.kind == KindDelIdx)
                    begin
                        pos_next = {1'b0, req.index};
                        if ({1'b0, req.index} >= count_reg)
                        begin
                            status_next = StBadIndex;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            status_next = StDeleted;
                            cur_next    = {1'b0, req.index} + CountW'(1);
                            pend_next   = 1'b0;
                            state_next  = S_DN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        found_next = 1'b0;
                        where_next = '0;
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = cnt_m1[AddrW-1:0];
                        state_next = S_HI;
                    end
                end
            end

            S_HI:
            begin
                mem_raddr  = hi_reg;
                state_next = S_LO;
            end

            // Upper end of the window is on the read port.
            S_LO:
            begin
                mem_raddr = lo_reg;
                if (cmp.gt)
                begin
                    found_next = 1'b0;
                    where_next = hi_p1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    eqhi_next  = cmp.eq;
                    state_next = S_CHK;
                end
            end

            // Lower end of the window is on the read port.
            S_CHK:
            begin
                mem_raddr = mid;
                priority if (cmp.lt)
                begin
                    found_next = 1'b0;
                    where_next = {1'b0, lo_reg};
                    state_next = S_DECIDE;
                end
                else if (cmp.eq)
                begin
                    found_next = 1'b1;
                    where_next = {1'b0, lo_reg};
                    state_next = S_DECIDE;
                end
                else if (eqhi_reg)
                begin
                    found_next = 1'b1;
                    where_next = {1'b0, hi_reg};
                    state_next = S_DECIDE;
                end
                else if (lo_reg >= hi_reg)
                begin
                    found_next = 1'b0;
                    where_next = count_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_MID;
                end
            end

            // Midpoint is on the read port: hit or halve the window.
            S_MID:
            begin
                priority if (cmp.eq)
                begin
                    found_next = 1'b1;
                    where_next = {1'b0, mid};
                    state_next = S_DECIDE;
                end
                else if (cmp.lt)
                begin
                    hi_next    = (mid != '0) ? mid - AddrW'(1) : mid;
                    state_next = S_HI;
                end
                else
                begin
                    lo_next    = mid + AddrW'(1);
                    state_next = S_HI;
                end
            end

            S_DECIDE:
            begin
                pos_next = where_reg;
                unique case (kind_reg)
                    KindInsert:
                    begin
                        if (found_reg && !cfg.dup)
                        begin
                            status_next = StPresent;
                            state_next  = S_FIN;
                        end
                        else if (count_reg >= cfg.cap)
                        begin
                            status_next = StFull;
                            pos_next    = '0;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            status_next = found_reg ? StPresent : StInserted;
                            cur_next    = count_reg;
                            pend_next   = 1'b0;
                            state_next  = S_UP;
                        end
                    end
                    KindDelKey:
                    begin
                        if (found_reg)
                        begin
                            status_next = StDeleted;
                            cur_next    = where_reg + CountW'(1);
                            pend_next   = 1'b0;
                            state_next  = S_DN;
                        end
                        else
                        begin
                            status_next = StNotFound;
                            state_next  = S_FIN;
                        end
                    end
                    KindLookup:
                    begin
                        status_next = found_reg ? StFound : StNotFound;
                        state_next  = S_FIN;
                    end
                    KindDelIdx:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // Move keys up one slot, from the top down to the insert slot.
            S_UP:
            begin
                mem_we = pend_reg;
                if (cur_reg > where_reg)
                begin
                    mem_raddr = cur_m1[AddrW-1:0];
                    dst_next  = cur_reg[AddrW-1:0];
                    cur_next  = cur_m1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = where_reg[AddrW-1:0];
                mem_wdata  = key_reg;
                count_next = count_reg + CountW'(1);
                state_next = S_FIN;
            end

            // Move keys above the freed slot down one slot.
            S_DN:
            begin
                mem_we = pend_reg;
                if (cur_reg < count_reg)
                begin
                    mem_raddr = cur_reg[AddrW-1:0];
                    dst_next  = cur_m1[AddrW-1:0];
                    cur_next  = cur_reg + CountW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = cnt_m1;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        eqhi_reg   <= eqhi_next;
        found_reg  <= found_next;
        where_reg  <= where_next;
        cur_reg    <= cur_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    `SKT_ASSERT_ALWAYS(a_count_bound, count_reg <= CountW'(TableDepth))
    `SKT_ASSERT_IMPL(a_no_write_idle, state_reg == S_IDLE, !mem_we)
    `SKT_ASSERT_IMPL(a_mid_window, state_reg == S_MID, lo_reg < hi_reg)
    `SKT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `SKT_ASSERT_NEXT(a_count_step, 1'b1, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CountW'(1)) || (count_reg == $past(count_reg) - CountW'(1)))

endmodule

// ===== sv/sorted_key_table_unit.sv =====
// Top level of the sorted key table: configuration registers and result register.
// Depends on skt_pkg and skt_seq.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//   req       in         req_valid/req_ready    req (kind, key, index)
//   rsp       out        rsp_valid/rsp_ready    rsp (status, position, entry_count)
//
// A search round reads the upper end, the lower end and the midpoint of the window through
// the single read port of the key memory into one comparator. An insert moves the keys from
// the insert position up one slot and then writes the new key; a delete moves the keys above
// the freed slot down one slot. Reset clears the key count; stored keys are never read before
// written. A finished word waits in the result register; a stalled rsp side holds the
// sequencer only when a second result is ready.
module sorted_key_table_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [skt_pkg::CountW-1:0] cfg_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  skt_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output skt_pkg::rsp_t             rsp
);
    import skt_pkg::*;

    logic [CountW-1:0] cap_reg;
    logic              dup_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    cfg_t              cfg;
    seq_res_t          res;
    logic              res_take;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CountW'(TableDepth);
            dup_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CfgCapacity: cap_reg <= cfg_data;
                CfgAllowDup: dup_reg <= cfg_data[0];
            endcase
        end
    end

    // Capacity limited to the table depth.
    assign cfg.cap = (cap_reg > CountW'(TableDepth)) ? CountW'(TableDepth) : cap_reg;
    assign cfg.dup = dup_reg;

    skt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg       (cfg),
        .res       (res),
        .res_take  (res_take)
    );

    // Result register between the sequencer and the rsp channel.
    assign res_take = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            rsp_reg <= res.rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
